@@ sv/prpc_pkg.sv @@
// Shared types, constants and character-class functions for the relative path checker.
package prpc_pkg;

  // One input item: a path byte, its end mark and the empty-path flag.
  typedef struct packed {
    logic [7:0] path_byte;
    logic       last_byte;
    logic       empty_path;
  } item_t;

  // One verdict per path.
  typedef struct packed {
    logic       path_valid;
    logic [1:0] error_code;
    logic [7:0] segment_total;
    logic [9:0] byte_total;
  } verdict_t;

  // Live limit registers.
  typedef struct packed {
    logic [9:0] max_path_length;
    logic [7:0] max_segment_length;
    logic [7:0] max_segment_count;
  } cfg_t;

  // Running state of the segment being received.
  typedef struct packed {
    logic [7:0]  length;
    logic [31:0] stem_prefix;
    logic [2:0]  stem_length;
    logic        dot_seen;
    logic        first_dot;
    logic        char_bad;
  } seg_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_FORM    = 2'd1;
  localparam logic [1:0] ERR_SEGMENT = 2'd2;

  localparam logic [1:0] REG_MAX_PATH_LENGTH    = 2'd0;
  localparam logic [1:0] REG_MAX_SEGMENT_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_SEGMENT_COUNT  = 2'd2;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [9:0] MAX_PATH_LENGTH_RST    = 10'd255;
  localparam logic [7:0] MAX_SEGMENT_LENGTH_RST = 8'd64;
  localparam logic [7:0] MAX_SEGMENT_COUNT_RST  = 8'd16;

  localparam logic [9:0] BYTE_COUNT_MAX  = 10'd1023;
  localparam logic [7:0] SEG_COUNT_MAX   = 8'd255;
  localparam logic [7:0] SEG_LENGTH_MAX  = 8'd255;
  localparam logic [2:0] STEM_LENGTH_MAX = 3'd7;
  localparam logic [2:0] STEM_KEEP       = 3'd4;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // Reserved stems, first byte in the low bits.
  localparam logic [23:0] STEM_CON = 24'h6E6F63;
  localparam logic [23:0] STEM_PRN = 24'h6E7270;
  localparam logic [23:0] STEM_AUX = 24'h787561;
  localparam logic [23:0] STEM_NUL = 24'h6C756E;
  localparam logic [23:0] STEM_COM = 24'h6D6F63;
  localparam logic [23:0] STEM_LPT = 24'h74706C;

  // Letters, digits, underscore, dash and dot.
  function automatic logic allowed_byte(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h5F || b == 8'h2D ||
           b == CHAR_DOT;
  endfunction

  function automatic logic [7:0] lower_byte(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic stem_reserved(input logic [31:0] prefix,
                                         input logic [2:0]  len);
    logic [23:0] three;
    logic [7:0]  fourth;
    logic        hit;
    three  = prefix[23:0];
    fourth = prefix[31:24];
    hit    = 1'b0;
    if (len == 3'd3) begin
      hit = three == STEM_CON || three == STEM_PRN ||
            three == STEM_AUX || three == STEM_NUL;
    end else if (len == 3'd4 && fourth >= 8'h31 && fourth <= 8'h39) begin
      hit = three == STEM_COM || three == STEM_LPT;
    end
    return hit;
  endfunction

  // Verdict on a segment at its closing slash or at the path end.
  function automatic logic seg_bad(input seg_t       s,
                                   input logic [7:0] prev,
                                   input logic [7:0] count,
                                   input logic [7:0] max_count);
    return s.length == 8'd0 || s.char_bad || s.first_dot || prev == CHAR_DOT ||
           stem_reserved(s.stem_prefix, s.stem_length) || count >= max_count;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == SEG_COUNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

@@ sv/prpc_core.sv @@
// Path state registers and the combinational update that folds in one byte.
module prpc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  prpc_pkg::item_t    item,
  input  prpc_pkg::cfg_t     cfg,
  output logic               result_valid,
  output prpc_pkg::verdict_t result
);
  import prpc_pkg::*;

  logic [9:0] byte_count, byte_count_next;
  logic [7:0] segment_count, segment_count_next;
  seg_t       segment, segment_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic       starts_with_slash, starts_with_slash_next;
  logic       any_segment_bad, any_segment_bad_next;

  logic [7:0] b;
  logic       is_slash;
  logic [9:0] byte_inc;
  logic       slash_form;
  logic       bad_a, bad_b;
  logic [7:0] count_a, count_b;
  logic       any_a, any_b;
  seg_t       seg_after;
  logic [7:0] low_b;

  assign result_valid = item.empty_path | item.last_byte;

  always_comb begin
    b          = item.path_byte;
    is_slash   = b == CHAR_SLASH;
    low_b      = lower_byte(b);
    byte_inc   = (byte_count == BYTE_COUNT_MAX) ? byte_count : byte_count + 10'd1;
    slash_form = starts_with_slash || (byte_count == 10'd0 && is_slash) ||
                 byte_count >= cfg.max_path_length;

    // Close on a slash byte.
    bad_a   = seg_bad(segment, previous_byte, segment_count, cfg.max_segment_count);
    count_a = is_slash ? sat_inc8(segment_count) : segment_count;
    any_a   = any_segment_bad | (is_slash & bad_a);

    // Fold a non-slash byte into the open segment.
    seg_after = segment;
    if (is_slash) begin
      seg_after = '0;
    end else begin
      if (segment.length == 8'd0 && b == CHAR_DOT) seg_after.first_dot = 1'b1;
      if (segment.length >= cfg.max_segment_length) seg_after.char_bad = 1'b1;
      if (segment.length != SEG_LENGTH_MAX) seg_after.length = segment.length + 8'd1;
      if (!allowed_byte(b)) seg_after.char_bad = 1'b1;
      if (!segment.dot_seen) begin
        if (b == CHAR_DOT) begin
          seg_after.dot_seen = 1'b1;
        end else begin
          if (segment.stem_length < STEM_KEEP) begin
            for (int i = 0; i < 4; i++) begin
              if (segment.stem_length[1:0] == 2'(i)) begin
                seg_after.stem_prefix[8*i +: 8] = segment.stem_prefix[8*i +: 8] | low_b;
              end
            end
          end
          if (segment.stem_length != STEM_LENGTH_MAX) begin
            seg_after.stem_length = segment.stem_length + 3'd1;
          end
        end
      end
    end

    // Close at the path end.
    bad_b   = seg_bad(seg_after, b, count_a, cfg.max_segment_count);
    count_b = sat_inc8(count_a);
    any_b   = any_a | bad_b;

    if (item.empty_path) begin
      result.path_valid    = 1'b0;
      result.error_code    = ERR_FORM;
      result.segment_total = 8'd0;
      result.byte_total    = 10'd0;
    end else begin
      priority if (slash_form || is_slash) begin
        result.error_code = ERR_FORM;
      end else if (any_b) begin
        result.error_code = ERR_SEGMENT;
      end else begin
        result.error_code = ERR_NONE;
      end
      result.path_valid    = result.error_code == ERR_NONE;
      result.segment_total = count_b;
      result.byte_total    = byte_inc;
    end

    if (item.empty_path || item.last_byte) begin
      byte_count_next        = '0;
      segment_count_next     = '0;
      segment_next           = '0;
      previous_byte_next     = '0;
      starts_with_slash_next = 1'b0;
      any_segment_bad_next   = 1'b0;
    end else begin
      byte_count_next        = byte_inc;
      segment_count_next     = count_a;
      segment_next           = seg_after;
      previous_byte_next     = b;
      starts_with_slash_next = slash_form;
      any_segment_bad_next   = any_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      segment_count     <= '0;
      segment           <= '0;
      previous_byte     <= '0;
      starts_with_slash <= 1'b0;
      any_segment_bad   <= 1'b0;
    end else if (step) begin
      byte_count        <= byte_count_next;
      segment_count     <= segment_count_next;
      segment           <= segment_next;
      previous_byte     <= previous_byte_next;
      starts_with_slash <= starts_with_slash_next;
      any_segment_bad   <= any_segment_bad_next;
    end
  end

  a_valid_matches_code: assert property (@(posedge clk) disable iff (rst)
    step && result_valid |-> result.path_valid == (result.error_code == ERR_NONE))
    else $error("path_valid disagrees with error_code");

  a_path_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && result_valid |=> byte_count == 10'd0 && segment_count == 8'd0 &&
                             !any_segment_bad)
    else $error("path state not cleared after a verdict");

  a_mid_path_counts: assert property (@(posedge clk) disable iff (rst)
    step && !result_valid |=> byte_count != 10'd0)
    else $error("byte count lost inside a path");

endmodule

@@ sv/portable_relative_path_checker.sv @@
// Top level of the relative path checker: limit registers, item and verdict registers.
//
// Usage:
//   Send a path one byte per transfer on the item channel (item_valid /
//   item_ready / item), with last_byte set on the final byte. An empty path
//   is one transfer with empty_path set; it also drops any partial path.
//   One verdict per path leaves on the verdict channel (verdict_valid /
//   verdict_ready / verdict) after the last byte or the empty-path transfer.
//   Verdict path: the item register loads the last byte on its transfer,
//   and the verdict register loads the core's result when that byte
//   advances out of the item register.
//   Throughput: one byte per cycle unless a path end stalls; the per-byte
//   update is a single pass through the core between the two registers.
//   Stall: while a verdict waits, bytes that end no path keep flowing; a
//   path end holds in the item register until the verdict register frees,
//   and item_ready drops only then.
//   Reset (rst, synchronous): clears path state, empties both registers and
//   loads the limits with 255 bytes per path, 64 per segment, 16 segments.
//   Limits are written through the APB port at 0x0, 0x4 and 0x8; write them
//   only while no path is in flight.
module portable_relative_path_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  prpc_pkg::item_t                 item,
  output logic                            verdict_valid,
  input  logic                            verdict_ready,
  output prpc_pkg::verdict_t              verdict,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prpc_pkg::ADDR_W-1:0]     paddr,
  input  logic [prpc_pkg::DATA_W-1:0]     pwdata,
  output logic [prpc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import prpc_pkg::*;

  cfg_t       cfg;
  logic [1:0] reg_index;
  logic       cfg_write;

  logic       s1_valid;
  item_t      s1_item;
  logic       s1_advance;

  logic       core_result_valid;
  verdict_t   core_result;

  // Register file: decode on the word index, ignore the byte lanes.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_path_length    <= MAX_PATH_LENGTH_RST;
      cfg.max_segment_length <= MAX_SEGMENT_LENGTH_RST;
      cfg.max_segment_count  <= MAX_SEGMENT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_MAX_PATH_LENGTH:    cfg.max_path_length    <= pwdata[9:0];
        REG_MAX_SEGMENT_LENGTH: cfg.max_segment_length <= pwdata[7:0];
        REG_MAX_SEGMENT_COUNT:  cfg.max_segment_count  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MAX_PATH_LENGTH:    prdata = {{(DATA_W-10){1'b0}}, cfg.max_path_length};
      REG_MAX_SEGMENT_LENGTH: prdata = {{(DATA_W-8){1'b0}}, cfg.max_segment_length};
      REG_MAX_SEGMENT_COUNT:  prdata = {{(DATA_W-8){1'b0}}, cfg.max_segment_count};
      default:                prdata = '0;
    endcase
  end

  // Advance the held byte unless it ends a path and the verdict slot is stuck.
  assign s1_advance = s1_valid & (~core_result_valid | ~verdict_valid | verdict_ready);
  assign item_ready = ~s1_valid | s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  prpc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_advance),
    .item         (s1_item),
    .cfg          (cfg),
    .result_valid (core_result_valid),
    .result       (core_result)
  );

  // Verdict register: load on a path end, drop on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_advance && core_result_valid) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && core_result_valid) begin
      verdict <= core_result;
    end
  end

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_item))
    else $error("held item changed while stalled");

  a_verdict_loaded: assert property (@(posedge clk) disable iff (rst)
    s1_advance && core_result_valid |=> verdict_valid && verdict == $past(core_result))
    else $error("verdict register missed a path end");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && core_result_valid && verdict_valid && !verdict_ready |-> !item_ready)
    else $error("item taken while a path end is blocked");

endmodule

@@ dv/tb_portable_relative_path_checker.sv @@
// Self-checking testbench for the portable relative path checker: directed and random paths.
`timescale 1ns / 1ps

module tb_portable_relative_path_checker;
  import prpc_pkg::*;

  // Even with every verdict held by the longest receiver gap the run stays
  // well inside this bound; leave wide margin.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Receiver hold-off used once to fill the block and stall its input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Bound on the final wait for outstanding verdicts.
  localparam int unsigned DRAIN_LIMIT = 2000;

  logic              clk;
  logic              rst           = 1'b1;
  logic              item_valid    = 1'b0;
  logic              item_ready;
  item_t             item          = '0;
  logic              verdict_valid;
  logic              verdict_ready = 1'b0;
  verdict_t          verdict;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  portable_relative_path_checker u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Path rule predictor: limits as last written, plus the running path state.
  // ---------------------------------------------------------------------------
  logic [9:0]  lim_path_len = MAX_PATH_LENGTH_RST;
  logic [7:0]  lim_seg_len  = MAX_SEGMENT_LENGTH_RST;
  logic [7:0]  lim_seg_cnt  = MAX_SEGMENT_COUNT_RST;

  logic [9:0]  path_bytes;
  logic [7:0]  path_segs;
  logic [7:0]  prev_ch;
  logic        path_rooted;    // leading slash seen or path overran its limit
  logic        path_seg_err;   // some closed segment broke a rule
  logic [7:0]  seg_len;
  logic [31:0] stem_txt;       // folded stem bytes, first byte in the top octet
  logic [2:0]  stem_len;
  logic        seg_dot_seen;
  logic        seg_lead_dot;
  logic        seg_flawed;     // forbidden byte or segment overran its limit

  function automatic void start_segment();
    seg_len      = '0;
    stem_txt     = '0;
    stem_len     = '0;
    seg_dot_seen = 1'b0;
    seg_lead_dot = 1'b0;
    seg_flawed   = 1'b0;
  endfunction

  function automatic void start_path();
    path_bytes   = '0;
    path_segs    = '0;
    prev_ch      = '0;
    path_rooted  = 1'b0;
    path_seg_err = 1'b0;
    start_segment();
  endfunction

  function automatic logic legal_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_" || c == "-" || c == CHAR_DOT;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  // Device names: three-letter ones alone, com/lpt only with a digit 1..9.
  function automatic logic device_stem();
    logic [23:0] head;
    head = stem_txt[31:8];
    if (stem_len == 3'd3)
      return head == "con" || head == "prn" || head == "aux" || head == "nul";
    if (stem_len == 3'd4 && stem_txt[7:0] >= "1" && stem_txt[7:0] <= "9")
      return head == "com" || head == "lpt";
    return 1'b0;
  endfunction

  function automatic void close_segment();
    if (seg_len == 8'd0 || seg_flawed || seg_lead_dot || prev_ch == CHAR_DOT ||
        device_stem() || path_segs >= lim_seg_cnt)
      path_seg_err = 1'b1;
    if (path_segs != 8'hFF)
      path_segs = path_segs + 8'd1;
    start_segment();
  endfunction

  // Advance the path state by one transfer; return 1 when it ends a path.
  function automatic bit judge_byte(input item_t it, output verdict_t v);
    logic [7:0] c;
    c = it.path_byte;
    v = '0;
    if (it.empty_path) begin
      start_path();
      v.error_code = ERR_FORM;
      return 1'b1;
    end
    if ((path_bytes == 10'd0 && c == CHAR_SLASH) || path_bytes >= lim_path_len)
      path_rooted = 1'b1;
    if (path_bytes != 10'h3FF)
      path_bytes = path_bytes + 10'd1;
    if (c == CHAR_SLASH) begin
      close_segment();
    end else begin
      if (seg_len == 8'd0 && c == CHAR_DOT)
        seg_lead_dot = 1'b1;
      if (seg_len >= lim_seg_len || !legal_char(c))
        seg_flawed = 1'b1;
      if (seg_len != 8'hFF)
        seg_len = seg_len + 8'd1;
      if (!seg_dot_seen) begin
        if (c == CHAR_DOT) begin
          seg_dot_seen = 1'b1;
        end else begin
          if (stem_len < 3'd4)
            stem_txt[31 - 8 * int'(stem_len) -: 8] = fold_case(c);
          if (stem_len != 3'd7)
            stem_len = stem_len + 3'd1;
        end
      end
    end
    prev_ch = c;
    if (!it.last_byte)
      return 1'b0;
    close_segment();
    if (path_rooted || c == CHAR_SLASH)
      v.error_code = ERR_FORM;
    else if (path_seg_err)
      v.error_code = ERR_SEGMENT;
    else
      v.error_code = ERR_NONE;
    v.path_valid    = v.error_code == ERR_NONE;
    v.segment_total = path_segs;
    v.byte_total    = path_bytes;
    start_path();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the processes below.
  // ---------------------------------------------------------------------------
  item_t       bytes_to_send [$];
  verdict_t    verdicts_due [$];
  verdict_t    due_v;
  int unsigned failures          = 0;
  int unsigned verdicts_checked  = 0;
  int unsigned bytes_accepted    = 0;
  int unsigned items_queued      = 0;
  int unsigned settings_used     = 1;
  int unsigned cycle_count       = 0;
  int unsigned send_gap          = 0;
  int unsigned recv_gap          = 0;
  bit          send_idle_on      = 1'b1;
  bit          recv_idle_on      = 1'b1;
  logic        hold_arm          = 1'b0;
  logic        hold_done;
  int unsigned hold_cycles;
  wire         hold_active       = hold_cycles != 0;

  // Mostly back to back, some short pauses, a few long ones.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_verdict(input string why, input verdict_t want, input verdict_t got);
    failures++;
    if (failures <= 10)
      $display("%s: expected valid=%0b code=%0d segs=%0d bytes=%0d, got valid=%0b code=%0d segs=%0d bytes=%0d",
               why, want.path_valid, want.error_code, want.segment_total, want.byte_total,
               got.path_valid, got.error_code, got.segment_total, got.byte_total);
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: present the next queued byte, hold it until the transfer,
  // and predict the verdict from every accepted transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && item_ready) begin
        bytes_accepted++;
        if (judge_byte(item, due_v))
          verdicts_due.insert(verdicts_due.size(), due_v);
      end
      // Advance only when the slot is free; never touch a pending payload.
      if (!item_valid || item_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          item       <= bytes_to_send.pop_front();
          item_valid <= 1'b1;
          send_gap = pick_gap(send_idle_on);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict monitor: compare each transfer with the oldest prediction, then
  // pick the next ready level (random stalls, forced low during the hold-off).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      verdict_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (verdict_valid && verdict_ready) begin
        if (verdicts_due.size() == 0) begin
          flag_verdict("Verdict with nothing pending", '0, verdict);
        end else begin
          due_v = verdicts_due.pop_front();
          verdicts_checked++;
          if (verdict.path_valid !== due_v.path_valid || verdict.error_code !== due_v.error_code ||
              verdict.segment_total !== due_v.segment_total ||
              verdict.byte_total !== due_v.byte_total)
            flag_verdict("Verdict mismatch", due_v, verdict);
        end
      end
      if (recv_gap != 0)
        recv_gap--;
      else
        recv_gap = pick_gap(recv_idle_on);
      verdict_ready <= !hold_active && recv_gap == 0;
    end
  end

  // Long receiver hold-off, counted here; fires once after it is armed.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_arm && !hold_done) begin
      hold_cycles <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts still pending",
               cycle_count, verdicts_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  string       LEGAL_SET = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.";
  string       DEVICE_NAMES [6] = '{"con", "prn", "aux", "nul", "com", "lpt"};
  logic [7:0]  path_txt [$];

  // Append one character to the path under construction.
  function automatic void add_char(input logic [7:0] c);
    path_txt.insert(path_txt.size(), c);
  endfunction

  function automatic logic [7:0] legal_pick();
    return LEGAL_SET[$urandom_range(0, LEGAL_SET.len() - 1)];
  endfunction

  function automatic void push_item(input logic [7:0] b, input logic last, input logic empty);
    item_t it;
    it.path_byte  = b;
    it.last_byte  = last;
    it.empty_path = empty;
    bytes_to_send.insert(bytes_to_send.size(), it);
    items_queued++;
  endfunction

  // Empty path marker with junk in the byte and either end mark.
  function automatic void send_empty();
    push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endfunction

  function automatic void send_path();
    foreach (path_txt[i])
      push_item(path_txt[i], i == path_txt.size() - 1, 1'b0);
  endfunction

  function automatic void send_str(input string s);
    path_txt.delete();
    for (int i = 0; i < s.len(); i++)
      add_char(s[i]);
    send_path();
  endfunction

  // Path of 'segs' segments, each 'len' letters.
  function automatic void send_run(input int unsigned len, input int unsigned segs);
    path_txt.delete();
    for (int unsigned s = 0; s < segs; s++) begin
      if (s != 0)
        add_char(CHAR_SLASH);
      repeat (len) add_char("q");
    end
    send_path();
  endfunction

  // Mostly well-formed path with a sprinkling of every segment defect.
  function automatic void build_path(input int unsigned segs_max, input int unsigned len_max);
    int unsigned n;
    int unsigned k;
    int unsigned len;
    string       dev;
    path_txt.delete();
    n = $urandom_range(1, segs_max);
    if ($urandom_range(0, 29) == 0)
      add_char(CHAR_SLASH);
    for (int unsigned s = 0; s < n; s++) begin
      if (s != 0)
        add_char(CHAR_SLASH);
      k   = $urandom_range(0, 99);
      len = $urandom_range(1, len_max);
      if (k < 14) begin
        // device name in random case, sometimes with an extension or a tail
        dev = DEVICE_NAMES[$urandom_range(0, 5)];
        for (int i = 0; i < dev.len(); i++)
          add_char($urandom_range(0, 1) ? (dev[i] ^ 8'h20) : dev[i]);
        if (dev == "com" || dev == "lpt")
          add_char(8'("0" + $urandom_range(0, 9)));
        case ($urandom_range(0, 3))
          0: begin
            add_char(CHAR_DOT);
            repeat ($urandom_range(1, 3)) add_char(legal_pick());
          end
          1: add_char(legal_pick());
          default: ;
        endcase
      end else if (k < 20) begin
        // empty segment
      end else if (k < 26) begin
        add_char(CHAR_DOT);
        repeat (len) add_char(legal_pick());
      end else if (k < 32) begin
        repeat (len) add_char(legal_pick());
        add_char(CHAR_DOT);
      end else if (k < 38) begin
        repeat (len) add_char(legal_pick());
        path_txt[path_txt.size() - 1 - $urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      end else if (k < 42) begin
        repeat (len_max + $urandom_range(1, 3)) add_char(legal_pick());
      end else begin
        repeat (len) add_char(legal_pick());
      end
    end
    if ($urandom_range(0, 29) == 0)
      add_char(CHAR_SLASH);
    if (path_txt.size() == 0)
      add_char(legal_pick());
  endfunction

  // Queue about n_bytes transfers: shaped paths, with noise and broken paths.
  function automatic void random_traffic(input int unsigned n_bytes, input int unsigned segs_max,
                                         input int unsigned len_max);
    int unsigned start;
    int unsigned r;
    start = items_queued;
    while (items_queued - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_empty();
      end else if (r < 8) begin
        // path cut short by an empty marker
        repeat ($urandom_range(1, 5)) push_item(legal_pick(), 1'b0, 1'b0);
        send_empty();
      end else if (r < 14) begin
        path_txt.delete();
        repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
        send_path();
      end else begin
        build_path(segs_max, len_max);
        send_path();
      end
    end
  endfunction

  // Wait until every byte went through and every verdict came back, then
  // give the two-stage pipe time to empty before touching the limits.
  task automatic settle();
    while (bytes_to_send.size() != 0 || item_valid || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle completing at the edge.
  task automatic apb_xfer(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write all three limits, mirror them in the predictor, read them back.
  task automatic set_limits(input logic [9:0] pl, input logic [7:0] sl, input logic [7:0] sc);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    logic [31:0] mask;
    logic [31:0] rd;
    idx = '{REG_MAX_PATH_LENGTH, REG_MAX_SEGMENT_LENGTH, REG_MAX_SEGMENT_COUNT};
    val = '{32'(pl), 32'(sl), 32'(sc)};
    for (int i = 0; i < 3; i++)
      apb_xfer(idx[i], 1'b1, val[i], rd);
    lim_path_len = pl;
    lim_seg_len  = sl;
    lim_seg_cnt  = sc;
    for (int i = 0; i < 3; i++) begin
      apb_xfer(idx[i], 1'b0, '0, rd);
      mask = (idx[i] == REG_MAX_PATH_LENGTH) ? 32'h3FF : 32'hFF;
      if ((rd & mask) !== val[i]) begin
        failures++;
        if (failures <= 10)
          $display("Limit register %0d read back 0x%0h, expected 0x%0h", idx[i], rd, val[i]);
      end
    end
    settings_used++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    start_path();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset limits: every rule once, edge of the default segment count.
    send_str("Ab_9-z.TXT");
    push_item(8'hA5, 1'b1, 1'b1);        // empty marker, end mark set
    push_item(8'h5A, 1'b0, 1'b1);        // empty marker, end mark clear
    send_str("/a");
    send_str("a/");
    send_str("/");
    send_str("a//b");
    send_str(".a");
    send_str("a.");
    send_str("CON");
    send_str("nul.txt");
    send_str("Com7");
    send_str("lpt1.x");
    send_str("com0");
    send_str("cons");
    send_str("aux_");
    send_str("a b");
    push_item(8'h00, 1'b0, 1'b0);        // lowest and highest byte values
    push_item(8'hFF, 1'b1, 1'b0);
    push_item("a", 1'b0, 1'b0);          // partial path dropped by empty marker
    push_item("b", 1'b0, 1'b0);
    send_empty();
    send_run(1, 16);
    send_run(1, 17);
    settle();

    // Tight limits with a long receiver hold-off: sender keeps offering
    // so the block fills up and drops item_ready.
    set_limits(10'd12, 8'd4, 8'd3);
    send_idle_on = 1'b0;
    hold_arm <= 1'b1;
    random_traffic(200, 4, 5);
    settle();
    send_idle_on = 1'b1;

    // Smallest legal limits, no idling on either side.
    set_limits(10'd1, 8'd1, 8'd1);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    send_str("a");
    send_str("ab");
    random_traffic(60, 2, 2);
    settle();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // Largest limits: one segment a byte past the widest segment limit.
    set_limits(10'd1023, 8'd255, 8'd255);
    send_run(256, 1);
    random_traffic(80, 6, 10);
    settle();

    // Zero limits: any nonempty path fails.
    set_limits('0, '0, '0);
    send_str("a");
    random_traffic(40, 3, 4);
    settle();

    // Two random mid-range settings.
    repeat (2) begin
      set_limits(10'($urandom_range(1, 40)), 8'($urandom_range(1, 12)),
                 8'($urandom_range(1, 8)));
      random_traffic(70, 5, 8);
      settle();
    end

    // Final drain with its own bound, then report.
    while (bytes_to_send.size() != 0 || item_valid)
      @(negedge clk);
    for (int unsigned w = 0; w < DRAIN_LIMIT && verdicts_due.size() != 0; w++)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      failures++;
      $display("%0d predicted verdicts never arrived", verdicts_due.size());
    end

    $display("Checked %0d verdicts from %0d byte transfers under %0d limit settings,",
             verdicts_checked, bytes_accepted, settings_used);
    $display("covering empty and broken paths, device names, limit edges and back-pressure.");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", failures);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/prpc_pkg.sv
sv/prpc_core.sv
sv/portable_relative_path_checker.sv
dv/tb_portable_relative_path_checker.sv
